@@ sv/apr_pkg.sv @@
package apr_pkg;

	// default sizes of the frame table
	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int AGE_BITS_DEF  = 8;

	// fixed field widths
	localparam int PAGE_W        = 16;
	localparam int INDEX_W       = 4;
	localparam int COUNT_W       = 16;
	localparam int FRAME_COUNT_W = 5;

	localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 5'd16;
	localparam logic [COUNT_W-1:0]       COUNT_MAX         = '1;

	// one page reference
	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              last_reference;
	} ref_item_t;

	// one result
	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] frame_index;
		logic               replaced;
		logic [COUNT_W-1:0] repl_count;
		logic               string_done;
	} res_item_t;

endpackage

@@ sv/aging_page_replacement.sv @@
// Aging page replacement: each item on the ref channel is one page reference and yields
// exactly one result on the res channel. The block keeps a table of frames (page, valid,
// age); every reference shifts the ages of the frames in use right by one, a hit sets the
// top age bit, a miss fills the next empty frame or evicts the lowest-numbered frame with
// the smallest age and counts a saturating replacement. After an item with last_reference
// set, the table and the count are cleared at once (no clearing pass). frame_count (written
// on cfg_we; the user writes it only while idle, the block itself does not enforce this;
// 0 reads as 1, values above FRAMES as FRAMES) selects how many frames are used. An item
// passes the accept state, a scan with one read per frame through the single read port of
// the page and age memories feeding one shared compare and minimum unit, a last state that
// waits for the registered read and an update state that writes back, which waits while an
// earlier result stalls. The next item may be accepted while a result still waits on res_stall.
module aging_page_replacement #(
	parameter int FRAMES    = apr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF,
	parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 ref_valid,
	output logic                                 ref_stall,
	input  apr_pkg::ref_item_t                   ref_item,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output apr_pkg::res_item_t                   res_item,
	input  logic                                 cfg_we,
	input  logic [apr_pkg::FRAME_COUNT_W-1:0]    cfg_data
);
	import apr_pkg::*;

	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]               state_q;
	logic [FRAME_COUNT_W-1:0] cfg_q;
	logic [CNT_W-1:0]         n_cfg;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         fill_q;
	logic [COUNT_W-1:0]       total_q;
	logic [COUNT_W-1:0]       total_nxt;
	logic [FRAMES-1:0]        valid_q;
	logic [PAGE_BITS-1:0]     page_q;
	logic                     last_q;

	logic                     rd_v_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [PAGE_BITS-1:0]     page_rd_s1;
	logic [AGE_BITS-1:0]      age_rd_s1;

	logic                     found_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [AGE_BITS-1:0]      hit_age_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [AGE_BITS-1:0]      best_age_q;

	logic                     res_valid_q;
	res_item_t                res_q;

	logic [PAGE_BITS-1:0]     page_mem [FRAMES];
	logic [AGE_BITS-1:0]      age_mem  [FRAMES];

	logic                     accept;
	logic                     upd_fire;
	logic                     do_fill;
	logic                     do_evict;
	logic [IDX_W-1:0]         pos;
	logic [IDX_W-1:0]         rd_idx;
	logic [AGE_BITS-1:0]      age_cur;
	logic [AGE_BITS-1:0]      age_sh;
	logic                     match;
	logic                     age_we;
	logic [IDX_W-1:0]         age_wa;
	logic [AGE_BITS-1:0]      age_wd;
	logic                     page_we;

	// frames in use, clamped to 1..FRAMES
	always_comb begin
		if (cfg_q == '0) begin
			n_cfg = CNT_W'(1);
		end else if (32'(cfg_q) > 32'(FRAMES)) begin
			n_cfg = CNT_W'(FRAMES);
		end else begin
			n_cfg = CNT_W'(cfg_q);
		end
	end

	// handshake
	assign ref_stall = (state_q != ST_IDLE);
	assign accept    = ref_valid && (state_q == ST_IDLE);
	assign upd_fire  = (state_q == ST_UPD) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;
	assign rd_idx    = cnt_q[IDX_W-1:0];

	// shared compare unit: aged value and match for the frame just read
	always_comb begin
		age_cur = valid_q[idx_s1] ? age_rd_s1 : '0;
		age_sh  = age_cur >> 1;
		match   = valid_q[idx_s1] && (page_rd_s1 == page_q);
	end

	// update decision after the scan
	always_comb begin
		do_fill  = !found_q && (fill_q < n_q);
		do_evict = !found_q && !do_fill;
		if (found_q) begin
			pos = hit_idx_q;
		end else if (do_fill) begin
			pos = fill_q[IDX_W-1:0];
		end else begin
			pos = best_idx_q;
		end
		if (do_evict && (total_q != COUNT_MAX)) begin
			total_nxt = total_q + COUNT_W'(1);
		end else begin
			total_nxt = total_q;
		end
	end

	// memory write port muxing: aged write-back during scan, final write at update
	always_comb begin
		page_we = upd_fire && !found_q;
		age_we  = rd_v_s1 || upd_fire;
		age_wa  = upd_fire ? pos : idx_s1;
		if (upd_fire) begin
			age_wd = found_q ? (hit_age_q | AGE_TOP) : AGE_TOP;
		end else begin
			age_wd = age_sh;
		end
	end

	// page and age memories, registered read
	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[pos] <= page_q;
		end
		if (age_we) begin
			age_mem[age_wa] <= age_wd;
		end
		page_rd_s1 <= page_mem[rd_idx];
		age_rd_s1  <= age_mem[rd_idx];
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= FRAME_COUNT_RESET;
			cnt_q       <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			valid_q     <= '0;
			rd_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			rd_v_s1 <= (state_q == ST_SCAN);
			// result register: loaded at update, emptied when taken
			if (upd_fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == n_q - CNT_W'(1)) begin
						state_q <= ST_LAST;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q     <= ST_IDLE;
						if (last_q) begin
							valid_q <= '0;
							fill_q  <= '0;
							total_q <= '0;
						end else begin
							total_q      <= total_nxt;
							valid_q[pos] <= 1'b1;
							if (do_fill) begin
								fill_q <= fill_q + CNT_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture, scan accumulators and result register
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
		if (accept) begin
			page_q  <= PAGE_BITS'(ref_item.page_number);
			last_q  <= ref_item.last_reference;
			n_q     <= n_cfg;
			found_q <= 1'b0;
		end
		if (rd_v_s1) begin
			if (match && !found_q) begin
				found_q   <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_age_q <= age_sh;
			end
			if ((idx_s1 == '0) || (age_sh < best_age_q)) begin
				best_age_q <= age_sh;
				best_idx_q <= idx_s1;
			end
		end
		if (upd_fire) begin
			res_q.hit         <= found_q;
			res_q.frame_index <= INDEX_W'(pos);
			res_q.replaced    <= do_evict;
			res_q.repl_count  <= total_nxt;
			res_q.string_done <= last_q;
		end
	end

endmodule

@@ sv/apr_checker.sv @@
module apr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              ref_valid,
	input logic                              ref_stall,
	input logic                              res_valid,
	input logic                              res_stall,
	input apr_pkg::res_item_t                res_item
);
	import apr_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// an accepted item keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ref_valid && !ref_stall |=> ref_stall)
		else $error("block ready right after accepting an item");

	// a new result only follows a busy period
	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(ref_stall))
		else $error("result without an item in flight");

	// a hit never evicts, an eviction always counts
	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_item.hit && res_item.replaced) &&
			(!res_item.replaced || (res_item.repl_count != '0)))
		else $error("inconsistent hit, replacement and count");

endmodule

bind aging_page_replacement apr_checker u_apr_checker (.*);

@@ tb/sv/page_table_checker.sv @@
`timescale 1ns / 1ps

module page_table_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ref_valid,
	input  logic                              ref_stall,
	input  apr_pkg::ref_item_t                ref_item,
	input  logic                              res_valid,
	input  logic                              res_stall,
	input  apr_pkg::res_item_t                res_item,
	input  logic                              cfg_we,
	input  logic [apr_pkg::FRAME_COUNT_W-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending_lookups
);

	import apr_pkg::*;

	localparam int NUM_FRAMES = FRAMES_DEF;
	localparam int AGE_W      = AGE_BITS_DEF;

	localparam logic [AGE_W-1:0] AGE_TOP = {1'b1, {(AGE_W-1){1'b0}}};

	// predicted frame table
	logic [PAGE_W-1:0]        frame_page  [NUM_FRAMES];
	logic                     frame_used  [NUM_FRAMES];
	logic [AGE_W-1:0]         frame_age   [NUM_FRAMES];
	int                       fill_ptr;
	logic [COUNT_W-1:0]       evict_total;
	logic [FRAME_COUNT_W-1:0] frame_limit;

	res_item_t expected_lookups[$];
	int        mismatches;

	function automatic void clear_frames();
		int i;
		for (i = 0; i < NUM_FRAMES; i++) begin
			frame_page[i] = '0;
			frame_used[i] = 1'b0;
			frame_age[i]  = '0;
		end
		fill_ptr    = 0;
		evict_total = '0;
	endfunction

	// one reference against the predicted table
	function automatic res_item_t predict_lookup(input ref_item_t item);
		res_item_t        r;
		int               n;
		int               pos;
		int               i;
		bit               found;
		logic [AGE_W-1:0] best;
		if (frame_limit == 0)
			n = 1;
		else if (frame_limit > NUM_FRAMES)
			n = NUM_FRAMES;
		else
			n = int'(frame_limit);
		found = 1'b0;
		pos   = 0;
		r     = '0;

		// age every frame in use
		for (i = 0; i < n; i++)
			frame_age[i] = frame_age[i] >> 1;

		// first resident match
		for (i = 0; i < n && !found; i++) begin
			if (frame_used[i] && frame_page[i] == item.page_number) begin
				found = 1'b1;
				pos   = i;
			end
		end

		if (found) begin
			r.hit = 1'b1;
			frame_age[pos] = frame_age[pos] | AGE_TOP;
		end else if (fill_ptr < n) begin
			pos = fill_ptr;
			frame_page[pos] = item.page_number;
			frame_used[pos] = 1'b1;
			frame_age[pos]  = frame_age[pos] | AGE_TOP;
			fill_ptr++;
		end else begin
			// evict lowest-numbered frame with the smallest age
			best = frame_age[0];
			pos  = 0;
			for (i = 1; i < n; i++) begin
				if (frame_age[i] < best) begin
					best = frame_age[i];
					pos  = i;
				end
			end
			frame_page[pos] = item.page_number;
			frame_used[pos] = 1'b1;
			frame_age[pos]  = AGE_TOP;
			r.replaced = 1'b1;
			if (evict_total != COUNT_MAX)
				evict_total = evict_total + COUNT_W'(1);
		end

		r.frame_index = INDEX_W'(pos);
		r.repl_count  = evict_total;
		r.string_done = item.last_reference;
		if (item.last_reference)
			clear_frames();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t page_table_checker: %s got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// watch both channels and the frame count register
	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			clear_frames();
			frame_limit = FRAME_COUNT_RESET;
			expected_lookups.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_lookups <= 0;
		end else begin
			// result side first: a result never belongs to an item taken at the same edge
			if (res_valid && !res_stall) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("unexpected result item", int'(res_item), 0);
				end else begin
					want = expected_lookups.pop_front();
					if (res_item.hit !== want.hit)
						report_mismatch("hit", int'(res_item.hit), int'(want.hit));
					if (res_item.frame_index !== want.frame_index)
						report_mismatch("frame_index", int'(res_item.frame_index),
							int'(want.frame_index));
					if (res_item.replaced !== want.replaced)
						report_mismatch("replaced", int'(res_item.replaced),
							int'(want.replaced));
					if (res_item.repl_count !== want.repl_count)
						report_mismatch("repl_count", int'(res_item.repl_count),
							int'(want.repl_count));
					if (res_item.string_done !== want.string_done)
						report_mismatch("string_done", int'(res_item.string_done),
							int'(want.string_done));
				end
			end
			if (ref_valid && !ref_stall)
				expected_lookups.push_back(predict_lookup(ref_item));
			if (cfg_we)
				frame_limit = cfg_data;
			fail_count <= mismatches;
			pending_lookups <= expected_lookups.size();
		end
	end

endmodule

@@ tb/sv/tb_aging_page_replacement.sv @@
`timescale 1ns / 1ps

module tb_aging_page_replacement;

	import apr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int SAT_ITEMS    = 40;
	localparam int PHASE_ITEMS  = 124;
	localparam int NUM_PHASES   = 10;

	logic                     clk;
	logic                     arst_n;
	logic                     ref_valid;
	logic                     ref_stall;
	ref_item_t                ref_item;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	res_item_t                res_item;
	logic                     cfg_we;
	logic [FRAME_COUNT_W-1:0] cfg_data;

	int fail_count;
	int pending_lookups;
	int cycle_count = 0;
	int send_idle_pct;
	int res_stall_pct;

	logic [FRAME_COUNT_W-1:0] frame_settings [NUM_PHASES] =
		'{5'd16, 5'd31, 5'd17, 5'd1, 5'd0, 5'd2, 5'd8, 5'd0, 5'd0, 5'd16};

	aging_page_replacement uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ref_valid (ref_valid),
		.ref_stall (ref_stall),
		.ref_item  (ref_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	page_table_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.ref_valid       (ref_valid),
		.ref_stall       (ref_stall),
		.ref_item        (ref_item),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res_item        (res_item),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_lookups (pending_lookups)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random stall on the result side
	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < res_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_aging_page_replacement NOT OK");
			$finish;
		end
	end

	task automatic set_idle_mode(input int mode);
		case (mode % 4)
			0: begin
				send_idle_pct = 0;
				res_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 65;
				res_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				res_stall_pct = 65;
			end
			default: begin
				send_idle_pct = 34;
				res_stall_pct = 34;
			end
		endcase
	endtask

	// present one reference item and hold it until taken
	task automatic send_reference(input logic [PAGE_W-1:0] page, input logic last);
		ref_item_t item;
		item.page_number    = page;
		item.last_reference = last;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			ref_valid <= 1'b0;
			@(posedge clk);
		end
		ref_valid <= 1'b1;
		ref_item  <= item;
		@(posedge clk);
		while (ref_stall)
			@(posedge clk);
	endtask

	// write the frame count once the block has drained
	task automatic set_frames(input logic [FRAME_COUNT_W-1:0] value);
		ref_valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups != 0)
			@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// strings drawn from a small working set, with some noise
	task automatic run_strings(input int items);
		int                left;
		int                str_len;
		int                pool;
		int                i;
		bit                close_string;
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] page;
		logic              last;
		left = items;
		while (left > 0) begin
			str_len      = $urandom_range(1, 60);
			pool         = $urandom_range(1, 32);
			base         = PAGE_W'($urandom);
			close_string = ($urandom_range(0, 7) != 0);
			for (i = 0; i < str_len && left > 0; i++) begin
				if ($urandom_range(0, 9) == 0)
					page = PAGE_W'($urandom);
				else
					page = base + PAGE_W'($urandom_range(0, pool - 1));
				last = (close_string && i == str_len - 1) || ($urandom_range(0, 49) == 0);
				send_reference(page, last);
				left--;
			end
		end
	endtask

	initial begin
		int                       i;
		int                       phase;
		logic [FRAME_COUNT_W-1:0] setting;
		arst_n        = 1'b0;
		ref_valid     = 1'b0;
		ref_item      = '0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		send_idle_pct = 0;
		res_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes at the reset frame count, hit and string end
		send_reference(16'h0000, 1'b0);
		send_reference(16'hFFFF, 1'b0);
		send_reference(16'h0000, 1'b0);
		send_reference(16'hFFFF, 1'b1);
		send_reference(16'hFFFF, 1'b0);

		// frame count changed in the middle of a string
		set_frames(5'd4);
		send_reference(16'h0010, 1'b0);
		send_reference(16'h0011, 1'b0);
		send_reference(16'h0012, 1'b0);
		send_reference(16'h0013, 1'b0);
		send_reference(16'h0011, 1'b0);
		set_frames(5'd2);
		send_reference(16'h0020, 1'b0);
		send_reference(16'h0013, 1'b0);
		set_frames(5'd8);
		send_reference(16'h0021, 1'b0);
		send_reference(16'h0013, 1'b0);
		send_reference(16'h0012, 1'b1);

		// out of range counts: zero acts as one, above the table as full size
		set_frames(5'd0);
		send_reference(16'hAAAA, 1'b0);
		send_reference(16'h5555, 1'b0);
		send_reference(16'hAAAA, 1'b1);
		set_frames(5'd31);
		send_reference(16'h1234, 1'b0);
		send_reference(16'h1234, 1'b1);

		// one string on a single frame, every miss after the first evicts
		set_frames(5'd1);
		send_reference(16'h1234, 1'b0);
		send_reference(16'h1234, 1'b0);
		for (i = 0; i < SAT_ITEMS; i++)
			send_reference(i[0] ? 16'hAAAA : 16'h5555, 1'b0);
		send_reference(16'h5555, 1'b1);
		send_reference(16'h5555, 1'b0);

		// random strings over several settings and idle modes
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			setting = frame_settings[phase];
			if (phase == 7 || phase == 8)
				setting = FRAME_COUNT_W'($urandom_range(0, 31));
			set_frames(setting);
			set_idle_mode(phase);
			run_strings(PHASE_ITEMS);
		end

		// drain and watch for stray results
		ref_valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_lookups == 0)
			$display("tb_aging_page_replacement OK");
		else
			$display("tb_aging_page_replacement NOT OK");
		$finish;
	end

endmodule
